// ----- rtl/prp_seg_pkg.sv -----
// shared types, constants and segment sizing for the prp dma segmenter
package prp_seg_pkg;

	localparam int PAGE_BITS    = 12;
	localparam int PAGE_BYTES   = 1 << PAGE_BITS;
	localparam int MAX_TRANSFER = 4194304;
	localparam int ADDR_W       = 64;
	localparam int LEN_W        = 23;
	localparam int SEG_W        = PAGE_BITS + 1;
	localparam int SUM_W        = SEG_W + 1;
	localparam int IDX_W        = 10;
	localparam int ENTRY_BITS   = 3;
	localparam int ENTRY_BYTES  = 1 << ENTRY_BITS;
	localparam int POS_W        = 14;
	localparam int N_RES        = 3;
	localparam int CNT_W        = 2;

	localparam logic OP_CMD   = 1'b0;
	localparam logic OP_ENTRY = 1'b1;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FETCH = 2'd1,
		KIND_ERROR = 2'd2,
		KIND_EMPTY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'b01,
		PH_WAIT = 2'b10
	} phase_t;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] first_pointer;
		logic [ADDR_W-1:0] second_pointer;
		logic [LEN_W-1:0]  byte_length;
		logic [ADDR_W-1:0] list_entry;
	} cmd_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] address;
		logic [SEG_W-1:0]  segment_bytes;
		logic [LEN_W-1:0]  buffer_offset;
		logic              last;
	} res_t;

	// bytes left, capped at one page and clipped at the page end of the address
	function automatic logic [SEG_W-1:0] seg_size(input logic [PAGE_BITS-1:0] offs,
		input logic [LEN_W-1:0] left);
		logic [SEG_W-1:0] size;
		logic [SUM_W-1:0] sum;
		size = (left < LEN_W'(PAGE_BYTES)) ? left[SEG_W-1:0] : SEG_W'(PAGE_BYTES);
		sum  = {1'b0, size} + SUM_W'(offs);
		if (sum > SUM_W'(PAGE_BYTES)) begin
			size = SEG_W'(PAGE_BYTES) - SEG_W'(offs);
		end
		return size;
	endfunction

endpackage

// ----- rtl/prp_seg_core.sv -----
// transfer state and result generation for one beat
module prp_seg_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  prp_seg_pkg::cmd_t                    cmd,
	output prp_seg_pkg::res_t [prp_seg_pkg::N_RES-1:0] res,
	output logic [prp_seg_pkg::CNT_W-1:0]        n_res
);

	prp_seg_pkg::phase_t                     phase_q, phase_d;
	logic [prp_seg_pkg::LEN_W-1:0]           bytes_left_q, bytes_left_d;
	logic [prp_seg_pkg::LEN_W-1:0]           bytes_done_q, bytes_done_d;
	logic [prp_seg_pkg::ADDR_W-1:0]          list_base_q, list_base_d;
	logic [prp_seg_pkg::IDX_W-1:0]           entry_index_q, entry_index_d;

	always_comb begin
		logic [prp_seg_pkg::LEN_W-1:0]  len;
		logic [prp_seg_pkg::SEG_W-1:0]  sz_a, sz_b, sz_e;
		logic [prp_seg_pkg::LEN_W-1:0]  left_a, left_b, left_e;
		logic [prp_seg_pkg::LEN_W-1:0]  done_a, done_b, done_e;
		logic [prp_seg_pkg::IDX_W-1:0]  idx_n;
		logic [prp_seg_pkg::IDX_W+prp_seg_pkg::ENTRY_BITS-1:0] idx_bytes;
		logic [prp_seg_pkg::POS_W-1:0]  pos_cmd, pos_ent;
		logic                           err_cmd, err_ent;

		len    = cmd.byte_length;
		sz_a   = prp_seg_pkg::seg_size(cmd.first_pointer[prp_seg_pkg::PAGE_BITS-1:0], len);
		left_a = len - prp_seg_pkg::LEN_W'(sz_a);
		done_a = prp_seg_pkg::LEN_W'(sz_a);
		sz_b   = prp_seg_pkg::seg_size(cmd.second_pointer[prp_seg_pkg::PAGE_BITS-1:0], left_a);
		left_b = left_a - prp_seg_pkg::LEN_W'(sz_b);
		done_b = done_a + prp_seg_pkg::LEN_W'(sz_b);

		sz_e   = prp_seg_pkg::seg_size(cmd.list_entry[prp_seg_pkg::PAGE_BITS-1:0], bytes_left_q);
		left_e = bytes_left_q - prp_seg_pkg::LEN_W'(sz_e);
		done_e = bytes_done_q + prp_seg_pkg::LEN_W'(sz_e);
		idx_n  = entry_index_q + prp_seg_pkg::IDX_W'(1);
		idx_bytes = {idx_n, prp_seg_pkg::ENTRY_BITS'(0)};

		pos_cmd = prp_seg_pkg::POS_W'(cmd.second_pointer[prp_seg_pkg::PAGE_BITS-1:0])
			+ prp_seg_pkg::POS_W'(prp_seg_pkg::ENTRY_BYTES);
		pos_ent = prp_seg_pkg::POS_W'(list_base_q[prp_seg_pkg::PAGE_BITS-1:0])
			+ prp_seg_pkg::POS_W'(idx_bytes)
			+ prp_seg_pkg::POS_W'(prp_seg_pkg::ENTRY_BYTES);
		err_cmd = pos_cmd > prp_seg_pkg::POS_W'(prp_seg_pkg::PAGE_BYTES);
		err_ent = pos_ent > prp_seg_pkg::POS_W'(prp_seg_pkg::PAGE_BYTES);

		res           = '0;
		n_res         = '0;
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		bytes_done_d  = bytes_done_q;
		list_base_d   = list_base_q;
		entry_index_d = entry_index_q;

		if (cmd.operation == prp_seg_pkg::OP_CMD) begin
			phase_d       = prp_seg_pkg::PH_IDLE;
			bytes_left_d  = '0;
			bytes_done_d  = '0;
			list_base_d   = '0;
			entry_index_d = '0;
			n_res         = prp_seg_pkg::CNT_W'(1);
			res[0].last   = 1'b1;
			priority if (len == '0) begin
				res[0].kind = prp_seg_pkg::KIND_EMPTY;
			end else if (len > prp_seg_pkg::LEN_W'(prp_seg_pkg::MAX_TRANSFER)) begin
				res[0].kind = prp_seg_pkg::KIND_ERROR;
			end else begin
				res[0].kind          = prp_seg_pkg::KIND_DATA;
				res[0].address       = cmd.first_pointer;
				res[0].segment_bytes = sz_a;
				res[0].last          = (left_a == '0);
				bytes_left_d         = left_a;
				bytes_done_d         = done_a;
				priority if (left_a == '0) begin
					n_res = prp_seg_pkg::CNT_W'(1);
				end else if (left_a > prp_seg_pkg::LEN_W'(prp_seg_pkg::PAGE_BYTES)) begin
					// second pointer names the list page
					n_res                = prp_seg_pkg::CNT_W'(2);
					list_base_d          = cmd.second_pointer;
					res[1].buffer_offset = done_a;
					if (err_cmd) begin
						res[1].kind = prp_seg_pkg::KIND_ERROR;
						res[1].last = 1'b1;
					end else begin
						res[1].kind    = prp_seg_pkg::KIND_FETCH;
						res[1].address = cmd.second_pointer;
						phase_d        = prp_seg_pkg::PH_WAIT;
					end
				end else begin
					n_res                = prp_seg_pkg::CNT_W'(2);
					res[1].kind          = prp_seg_pkg::KIND_DATA;
					res[1].address       = cmd.second_pointer;
					res[1].segment_bytes = sz_b;
					res[1].buffer_offset = done_a;
					res[1].last          = (left_b == '0);
					bytes_left_d         = left_b;
					bytes_done_d         = done_b;
					if (left_b != '0) begin
						n_res                = prp_seg_pkg::CNT_W'(3);
						res[2].kind          = prp_seg_pkg::KIND_ERROR;
						res[2].buffer_offset = done_b;
						res[2].last          = 1'b1;
					end
				end
			end
		end else if (phase_q == prp_seg_pkg::PH_WAIT) begin
			n_res                = prp_seg_pkg::CNT_W'(1);
			res[0].kind          = prp_seg_pkg::KIND_DATA;
			res[0].address       = cmd.list_entry;
			res[0].segment_bytes = sz_e;
			res[0].buffer_offset = bytes_done_q;
			res[0].last          = (left_e == '0);
			bytes_left_d         = left_e;
			bytes_done_d         = done_e;
			if (left_e == '0) begin
				phase_d = prp_seg_pkg::PH_IDLE;
			end else begin
				n_res                = prp_seg_pkg::CNT_W'(2);
				entry_index_d        = idx_n;
				res[1].buffer_offset = done_e;
				if (err_ent) begin
					res[1].kind = prp_seg_pkg::KIND_ERROR;
					res[1].last = 1'b1;
					phase_d     = prp_seg_pkg::PH_IDLE;
				end else begin
					res[1].kind    = prp_seg_pkg::KIND_FETCH;
					res[1].address = list_base_q + prp_seg_pkg::ADDR_W'(idx_bytes);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= prp_seg_pkg::PH_IDLE;
			bytes_left_q  <= '0;
			bytes_done_q  <= '0;
			list_base_q   <= '0;
			entry_index_q <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			bytes_done_q  <= bytes_done_d;
			list_base_q   <= list_base_d;
			entry_index_q <= entry_index_d;
		end
	end

endmodule

// ----- rtl/prp_seg_outq.sv -----
// result register holding the results of one beat, drained one per cycle while stall is low
module prp_seg_outq (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       load,
	input  prp_seg_pkg::res_t [prp_seg_pkg::N_RES-1:0] res_in,
	input  logic [prp_seg_pkg::CNT_W-1:0]              n_in,
	input  logic                                       stall,
	output logic                                       valid,
	output prp_seg_pkg::res_t                          res_out,
	output logic                                       free
);

	prp_seg_pkg::res_t [prp_seg_pkg::N_RES-1:0] slot_q;
	logic [prp_seg_pkg::CNT_W-1:0]              n_q;
	logic [prp_seg_pkg::CNT_W-1:0]              rd_q;
	logic [prp_seg_pkg::CNT_W-1:0]              remaining;
	logic                                       pop;

	assign remaining = n_q - rd_q;
	assign valid     = (remaining != '0);
	assign pop       = valid && !stall;
	assign free      = (remaining == '0) || ((remaining == prp_seg_pkg::CNT_W'(1)) && pop);
	assign res_out   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= '0;
			rd_q <= '0;
		end else if (load) begin
			n_q  <= n_in;
			rd_q <= '0;
		end else if (pop) begin
			rd_q <= rd_q + prp_seg_pkg::CNT_W'(1);
		end
	end

`ifndef SYNTH
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= n_q)
		else $error("read index past result count");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		valid && res_out.last |-> (rd_q == n_q - prp_seg_pkg::CNT_W'(1)))
		else $error("last mark on a result that is not the final one");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("results loaded over undelivered results");
`endif

endmodule

// ----- rtl/prp_dma_segmenter.sv -----
// top level of the prp dma segmenter
// Takes command beats (prp1, prp2, length) and list entry beats and emits
// page-bounded data segments, list entry fetch requests, errors and empty
// completions. A beat is registered at the input, its results (up to three)
// are formed in a single pass over the registered transfer state and written
// together into the result register, which hands them out one per cycle while
// seg_stall is low. A new beat is taken every cycle while beats yield at most
// one result and seg_stall is low; a beat with two or three results holds the
// input while the result register drains. The next entry beat must be the
// one asked for by the latest fetch request; an entry beat with no fetch
// outstanding gives no result, and a new command abandons the current one.
module prp_dma_segmenter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic                                operation,
	input  logic [prp_seg_pkg::ADDR_W-1:0]      first_pointer,
	input  logic [prp_seg_pkg::ADDR_W-1:0]      second_pointer,
	input  logic [prp_seg_pkg::LEN_W-1:0]       byte_length,
	input  logic [prp_seg_pkg::ADDR_W-1:0]      list_entry,
	output logic                                seg_valid,
	input  logic                                seg_stall,
	output logic [1:0]                          kind,
	output logic [prp_seg_pkg::ADDR_W-1:0]      address,
	output logic [prp_seg_pkg::SEG_W-1:0]       segment_bytes,
	output logic [prp_seg_pkg::LEN_W-1:0]       buffer_offset,
	output logic                                last
);

	logic                                       cmd_valid_s1;
	prp_seg_pkg::cmd_t                          cmd_s1;
	logic                                       free;
	logic                                       fire;
	prp_seg_pkg::res_t [prp_seg_pkg::N_RES-1:0] res;
	logic [prp_seg_pkg::CNT_W-1:0]              n_res;
	prp_seg_pkg::res_t                          res_out;

	assign fire      = cmd_valid_s1 && free;
	assign cmd_stall = cmd_valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1.operation      <= operation;
			cmd_s1.first_pointer  <= first_pointer;
			cmd_s1.second_pointer <= second_pointer;
			cmd_s1.byte_length    <= byte_length;
			cmd_s1.list_entry     <= list_entry;
		end
	end

	prp_seg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.res    (res),
		.n_res  (n_res)
	);

	prp_seg_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fire),
		.res_in  (res),
		.n_in    (n_res),
		.stall   (seg_stall),
		.valid   (seg_valid),
		.res_out (res_out),
		.free    (free)
	);

	assign kind          = res_out.kind;
	assign address       = res_out.address;
	assign segment_bytes = res_out.segment_bytes;
	assign buffer_offset = res_out.buffer_offset;
	assign last          = res_out.last;

endmodule
